FILE: sv/lwkd_pkg.sv
// lwkd_pkg: shared widths, register map and controller/datapath command and status types
// for the longest-window-with-k-distinct block; no dependencies
`default_nettype none

package lwkd_pkg;

   localparam int MAX_WINDOW_DEF = 1024;

   localparam int SYM_W  = 8;
   localparam int BEST_W = 11;
   localparam int DIST_W = 9;
   localparam int NUM_SYMBOLS = 256;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from byte address bit 2
   localparam logic REG_MAX_DISTINCT = 1'b0;

   // source of the symbol counts read address
   typedef enum logic [1:0] {
      SEL_REQ = 2'd0,
      SEL_SYM = 2'd1,
      SEL_OLD = 2'd2
   } cnt_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        admit;
      logic        drop;
      logic        set_ovf;
      logic        emit;
      cnt_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic need_over;
      logic win_empty;
      logic win_full;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/lwkd_req_if.sv
// lwkd_req_if: input byte stream channel with valid/ready handshake
// depends on lwkd_pkg for field widths
`default_nettype none

interface lwkd_req_if;
   logic                      valid;
   logic                      ready;
   logic [lwkd_pkg::SYM_W-1:0] symbol;
   logic                      last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/lwkd_rsp_if.sv
// lwkd_rsp_if: result stream channel with valid/ready handshake
// depends on lwkd_pkg for field widths
`default_nettype none

interface lwkd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lwkd_pkg::BEST_W-1:0] best_length;
   logic                       last_res;
   logic                       overflow;

   modport source (output valid, output best_length, output last_res, output overflow,
                   input ready);
   modport sink   (input valid, input best_length, input last_res, input overflow,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/lwkd_ram.sv
// lwkd_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module lwkd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/lwkd_ctrl.sv
// lwkd_ctrl: sequencer for admit, drop-oldest and result hand-off
// depends on lwkd_pkg for command and status types
`default_nettype none

module lwkd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire lwkd_pkg::status_type status,
   output      lwkd_pkg::cmd_type    cmd
);
   import lwkd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_LOOK     = 6'b000010,
      ST_DROP_CNT = 6'b000100,
      ST_DROP_WR  = 6'b001000,
      ST_RELOOK   = 6'b010000,
      ST_HOLD     = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = SEL_SYM;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.rd_sel = SEL_REQ;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_LOOK;
            end
         end
         ST_LOOK: begin
            priority if (status.need_over && !status.win_empty) begin
               state_in = ST_DROP_CNT;
            end else if (!status.need_over && status.win_full) begin
               // store full: make room, then retry the admit
               cmd.set_ovf = 1'b1;
               state_in    = ST_DROP_CNT;
            end else begin
               cmd.admit = !status.need_over;
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_DROP_CNT: begin
            cmd.rd_sel = SEL_OLD;
            state_in   = ST_DROP_WR;
         end
         ST_DROP_WR: begin
            cmd.drop = 1'b1;
            state_in = ST_RELOOK;
         end
         ST_RELOOK: begin
            state_in = ST_LOOK;
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/lwkd_dpath.sv
// lwkd_dpath: symbol counts, window ring store, window registers and result register
// depends on lwkd_pkg and lwkd_ram
`default_nettype none

module lwkd_dpath #(
   parameter int MAX_WINDOW = lwkd_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lwkd_pkg::cmd_type           cmd,
   output      lwkd_pkg::status_type        status,
   input  wire logic [lwkd_pkg::DIST_W-1:0] max_distinct,
   input  wire logic [lwkd_pkg::SYM_W-1:0]  req_symbol,
   input  wire logic                        req_last,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [lwkd_pkg::BEST_W-1:0] rsp_best_length,
   output      logic                        rsp_last_res,
   output      logic                        rsp_overflow
);
   import lwkd_pkg::*;

   localparam int PW = $clog2(MAX_WINDOW);
   localparam int LW = $clog2(MAX_WINDOW + 1);

   // item registers
   logic [SYM_W-1:0] sym_ff;
   logic             last_ff;

   // window state
   logic [PW-1:0]     oldest_ff, oldest_in;
   logic [PW-1:0]     newest_ff, newest_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [DIST_W-1:0] distinct_ff, distinct_in;
   logic [LW-1:0]     longest_ff, longest_in;
   logic              overflow_ff, overflow_in;
   logic [NUM_SYMBOLS-1:0] cnt_valid_ff;

   // counts ram
   logic [SYM_W-1:0] cnt_raddr;
   logic [SYM_W-1:0] cnt_addr_ff;
   logic [LW-1:0]    cnt_q;
   logic [LW-1:0]    cnt_cur;
   logic             cnt_zero;
   logic             cnt_we;
   logic [LW-1:0]    cnt_wdata;

   // store ram
   logic [SYM_W-1:0] store_q;

   // result register
   logic              rsp_valid_ff;
   logic [BEST_W-1:0] rsp_best_ff;
   logic              rsp_last_ff;
   logic              rsp_ovf_ff;

   logic [DIST_W:0]        need;
   logic                   out_free;
   logic                   clear;
   logic [LW-1:0]          len_plus;
   logic [LW-1:0]          longest_upd;
   logic                   overflow_upd;
   logic [LW+BEST_W-1:0]   best_ext;

   lwkd_ram #(.WIDTH(LW), .DEPTH(NUM_SYMBOLS)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_addr_ff),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_q)
   );

   lwkd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_WINDOW)) u_store_ram (
      .clock (clock),
      .we    (cmd.admit),
      .waddr (newest_ff),
      .wdata (sym_ff),
      .raddr (oldest_ff),
      .rdata (store_q)
   );

   always_comb begin
      unique case (cmd.rd_sel)
         SEL_REQ: cnt_raddr = req_symbol;
         SEL_SYM: cnt_raddr = sym_ff;
         SEL_OLD: cnt_raddr = store_q;
         default: cnt_raddr = sym_ff;
      endcase
   end

   // an entry never written since the last clear reads as zero
   assign cnt_cur  = cnt_valid_ff[cnt_addr_ff] ? cnt_q : '0;
   assign cnt_zero = (cnt_cur == '0);
   assign need     = {1'b0, distinct_ff} + {{DIST_W{1'b0}}, cnt_zero};

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign clear    = cmd.emit && last_ff;
   assign len_plus = len_ff + LW'(1);

   assign cnt_we    = cmd.admit || (cmd.drop && !cnt_zero);
   assign cnt_wdata = cmd.admit ? (cnt_cur + LW'(1)) : (cnt_cur - LW'(1));

   assign longest_upd  = (cmd.admit && (len_plus > longest_ff)) ? len_plus : longest_ff;
   assign overflow_upd = overflow_ff || cmd.set_ovf;
   assign best_ext     = {{BEST_W{1'b0}}, longest_upd};

   always_comb begin
      oldest_in   = oldest_ff;
      newest_in   = newest_ff;
      len_in      = len_ff;
      distinct_in = distinct_ff;
      priority if (clear) begin
         oldest_in   = '0;
         newest_in   = '0;
         len_in      = '0;
         distinct_in = '0;
      end else if (cmd.admit) begin
         newest_in = (newest_ff == PW'(MAX_WINDOW - 1)) ? '0 : newest_ff + PW'(1);
         len_in    = len_plus;
         if (cnt_zero) begin
            distinct_in = distinct_ff + DIST_W'(1);
         end
      end else if (cmd.drop) begin
         oldest_in = (oldest_ff == PW'(MAX_WINDOW - 1)) ? '0 : oldest_ff + PW'(1);
         len_in    = len_ff - LW'(1);
         if ((cnt_cur == LW'(1)) && (distinct_ff != '0)) begin
            distinct_in = distinct_ff - DIST_W'(1);
         end
      end
      longest_in  = clear ? '0 : longest_upd;
      overflow_in = clear ? 1'b0 : overflow_upd;
   end

   always_ff @(posedge clock) begin
      cnt_addr_ff <= cnt_raddr;
      if (cmd.load_item) begin
         sym_ff  <= req_symbol;
         last_ff <= req_last;
      end
      if (cmd.emit) begin
         rsp_best_ff <= best_ext[BEST_W-1:0];
         rsp_last_ff <= last_ff;
         rsp_ovf_ff  <= overflow_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         newest_ff    <= '0;
         len_ff       <= '0;
         distinct_ff  <= '0;
         longest_ff   <= '0;
         overflow_ff  <= 1'b0;
         cnt_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         oldest_ff   <= oldest_in;
         newest_ff   <= newest_in;
         len_ff      <= len_in;
         distinct_ff <= distinct_in;
         longest_ff  <= longest_in;
         overflow_ff <= overflow_in;
         if (clear) begin
            cnt_valid_ff <= '0;
         end else if (cnt_we) begin
            cnt_valid_ff[cnt_addr_ff] <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.need_over = need > {1'b0, max_distinct};
   assign status.win_empty = (len_ff == '0);
   assign status.win_full  = (len_ff == LW'(MAX_WINDOW));
   assign status.out_free  = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = rsp_best_ff;
   assign rsp_last_res    = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: sv/longest_window_k_distinct.sv
// longest_window_k_distinct: top level, csr register, controller and datapath
// depends on lwkd_pkg, lwkd_req_if, lwkd_rsp_if, lwkd_ctrl, lwkd_dpath
//
//   channel  direction  transfer moves
//   req      in         symbol (8 bits), last (1 bit)
//   rsp      out        best_length (11 bits), last_res (1 bit), overflow (1 bit)
//   csr      in         apb write/read of max_distinct at byte address 0
//
// a byte that needs no drops is accepted, then gets one count lookup and its admit
// each dropped oldest byte passes through the shared counts ram port in order:
// (store read, count read, count write-back, re-lookup of the new symbol)
// reset needs no clearing pass: the counts carry per-entry valid bits
// a finished byte waits in the hold state while the result register is full and not taken
`default_nettype none

module longest_window_k_distinct #(
   parameter int MAX_WINDOW = lwkd_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lwkd_req_if.sink                             req_bus,
   lwkd_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lwkd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [lwkd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [lwkd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready
);
   import lwkd_pkg::*;

   logic [DIST_W-1:0] max_distinct_ff;
   logic              csr_write;
   cmd_type           cmd;
   status_type        status;
   logic              req_ready;

   // register write lands in the access phase; address bit 2 picks the word
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_MAX_DISTINCT);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_DISTINCT) ? CSR_DATA_W'(max_distinct_ff)
                                                          : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distinct_ff <= DIST_W'(1);
      end else if (csr_write) begin
         max_distinct_ff <= csr_pwdata[DIST_W-1:0];
      end
   end

   // sequencer: accept, lookup, drop loop, result hand-off
   lwkd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // counts, ring store, window registers and the result register
   lwkd_dpath #(.MAX_WINDOW(MAX_WINDOW)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .max_distinct    (max_distinct_ff),
      .req_symbol      (req_bus.symbol),
      .req_last        (req_bus.last),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_best_length (rsp_bus.best_length),
      .rsp_last_res    (rsp_bus.last_res),
      .rsp_overflow    (rsp_bus.overflow)
   );

endmodule

`default_nettype wire

FILE: dv/lwkd_checker.sv
// lwkd_checker: watches the byte and result channels and the csr port of the
// longest-window block, predicts every result and compares it on transfer
// depends on lwkd_pkg, lwkd_req_if and lwkd_rsp_if
`default_nettype none

module lwkd_checker #(
   parameter int WINDOW_DEPTH = lwkd_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lwkd_req_if                                  req_mon,
   lwkd_rsp_if                                  rsp_mon,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic                            csr_pready,
   input  wire logic [lwkd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [lwkd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                                   fail_count,
   output int                                   pending
);
   import lwkd_pkg::*;

   typedef struct packed {
      logic [BEST_W-1:0] best_length;
      logic              last_res;
      logic              overflow;
   } window_result_t;

   window_result_t    expected_results [$];

   logic [BEST_W-1:0] sym_count [NUM_SYMBOLS];
   logic [SYM_W-1:0]  win_bytes [WINDOW_DEPTH];
   int unsigned       oldest_idx;
   int unsigned       newest_idx;
   logic [BEST_W-1:0] win_len;
   logic [BEST_W-1:0] longest;
   logic [DIST_W-1:0] distinct;
   logic [DIST_W-1:0] limit;
   logic              ovf_seen;
   int                fails = 0;

   function automatic void clear_window();
      foreach (sym_count[i]) sym_count[i] = '0;
      oldest_idx = 0;
      newest_idx = 0;
      win_len    = '0;
      distinct   = '0;
      longest    = '0;
      ovf_seen   = 1'b0;
   endfunction

   function automatic void drop_oldest_byte();
      logic [SYM_W-1:0] s;
      s = win_bytes[oldest_idx];
      if (sym_count[s] != '0) begin
         sym_count[s] = sym_count[s] - 1'b1;
         if (sym_count[s] == '0 && distinct != '0) distinct = distinct - 1'b1;
      end
      oldest_idx = (oldest_idx + 1 >= WINDOW_DEPTH) ? 0 : oldest_idx + 1;
      win_len    = win_len - 1'b1;
   endfunction

   function automatic window_result_t advance_window(input logic [SYM_W-1:0] s,
                                                     input logic fin);
      int unsigned    need;
      window_result_t r;
      need = int'(distinct) + ((sym_count[s] == '0) ? 1 : 0);
      // shrink from the old end until the new byte fits the limit
      while (need > limit && win_len != '0) begin
         drop_oldest_byte();
         need = int'(distinct) + ((sym_count[s] == '0) ? 1 : 0);
      end
      if (need <= limit) begin
         if (win_len >= WINDOW_DEPTH) begin
            drop_oldest_byte();
            ovf_seen = 1'b1;
         end
         if (sym_count[s] == '0) distinct = distinct + 1'b1;
         sym_count[s]          = sym_count[s] + 1'b1;
         win_bytes[newest_idx] = s;
         newest_idx            = (newest_idx + 1 >= WINDOW_DEPTH) ? 0 : newest_idx + 1;
         win_len               = win_len + 1'b1;
         if (win_len > longest) longest = win_len;
      end
      r.best_length = longest;
      r.last_res    = fin;
      r.overflow    = ovf_seen;
      if (fin) clear_window();
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      window_result_t got;
      window_result_t want;
      if (reset) begin
         clear_window();
         limit = 9'd1;
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.best_length, rsp_mon.last_res, rsp_mon.overflow};
            if (expected_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("checker: unexpected result best_length %0d last_res %0b overflow %0b",
                           got.best_length, got.last_res, got.overflow);
            end else begin
               want = expected_results.pop_front();
               if (got.best_length !== want.best_length || got.last_res !== want.last_res ||
                   got.overflow !== want.overflow) begin
                  fails++;
                  if (fails <= 10)
                     $display({"checker: mismatch best_length exp %0d got %0d,",
                               " last_res exp %0b got %0b, overflow exp %0b got %0b"},
                              want.best_length, got.best_length, want.last_res,
                              got.last_res, want.overflow, got.overflow);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(advance_window(req_mon.symbol, req_mon.last));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_MAX_DISTINCT)
            limit = csr_pwdata[DIST_W-1:0];
      end
      fail_count <= fails;
      pending    <= expected_results.size();
   end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// tb: stimulus and verdict for longest_window_k_distinct
// depends on lwkd_pkg, lwkd_req_if, lwkd_rsp_if, the block and lwkd_checker
`default_nettype none

module tb;
   import lwkd_pkg::*;

   // small store so that full-store drops happen often
   localparam int WINDOW_DEPTH   = 64;
   localparam int CLOCK_PERIOD   = 8;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 60;
   // worst single byte: every stored byte dropped in turn
   localparam int DRAIN_CYCLES   = 4 * WINDOW_DEPTH + 32;
   localparam int TIMEOUT_CYCLES = 2000000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    results_pending;

   // no idling on either side while set
   logic                  calm = 1'b1;

   // random string state, carried across phases so limits change mid-string
   int                    str_left = 0;
   int                    alpha_n = 1;
   logic [SYM_W-1:0]      alphabet [8];
   int                    phase_limits [PHASES] = '{2, 0, 1, 256, 3, 257, 511, 5, 2, 4};

   lwkd_req_if req_bus ();
   lwkd_rsp_if rsp_bus ();

   longest_window_k_distinct #(
      .MAX_WINDOW (WINDOW_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lwkd_checker #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (mismatch_count),
      .pending     (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop if the run hangs
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("tb: failure");
      $finish;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: ready drops for random stretches, decided at each falling edge
   initial begin : rsp_stall
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = idle_cycles();
         if (stall == 0) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // one byte transfer; called and returns at a falling edge, valid left high
   task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic fin);
      int gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  = 1'b1;
      req_bus.symbol = sym;
      req_bus.last   = fin;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // wait for the block to go idle, then write the limit over apb
   task automatic set_limit(input logic [DIST_W-1:0] value);
      req_bus.valid = 1'b0;
      while (results_pending != 0) @(posedge clock);
      @(negedge clock);
      // setup cycle; junk above the register width must be ignored
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {REG_MAX_DISTINCT, 2'b00};
      csr_pwdata  = {23'($urandom), value};
      @(negedge clock);
      // access cycle
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // next byte of the running random string, opening a new string when needed
   task automatic push_random_symbol();
      logic [SYM_W-1:0] s;
      int               r;
      if (str_left == 0) begin
         r        = $urandom_range(0, 99);
         str_left = (r < 85) ? $urandom_range(1, 24) : $urandom_range(40, 160);
         alpha_n  = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : 8;
         foreach (alphabet[i]) alphabet[i] = 8'($urandom);
      end
      // a tenth of the bytes are noise outside the string's alphabet
      if ($urandom_range(0, 9) == 0) s = 8'($urandom);
      else s = alphabet[$urandom_range(0, alpha_n - 1)];
      str_left--;
      push_symbol(s, str_left == 0);
   endtask

   initial begin : stimulus
      logic [DIST_W-1:0] lim;
      req_bus.valid  = 1'b0;
      req_bus.symbol = '0;
      req_bus.last   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // limit of one from reset: runs of a single value, extreme bytes
      push_symbol(8'h00, 1'b0);
      push_symbol(8'h00, 1'b0);
      push_symbol(8'hFF, 1'b0);
      push_symbol(8'hFF, 1'b0);
      push_symbol(8'h5A, 1'b1);

      // limit zero admits nothing
      set_limit(9'd0);
      push_symbol(8'h07, 1'b0);
      push_symbol(8'h07, 1'b1);

      // limit two with drops, then lowered to one inside the same string
      set_limit(9'd2);
      push_symbol(8'h01, 1'b0);
      push_symbol(8'h02, 1'b0);
      push_symbol(8'h01, 1'b0);
      push_symbol(8'h03, 1'b0);
      push_symbol(8'h03, 1'b0);
      push_symbol(8'h03, 1'b0);
      set_limit(9'd1);
      push_symbol(8'h03, 1'b0);
      push_symbol(8'h04, 1'b1);

      // limit above the symbol count acts as no limit
      set_limit(9'd257);
      push_symbol(8'hA5, 1'b0);
      push_symbol(8'h5A, 1'b0);
      push_symbol(8'hC3, 1'b0);
      push_symbol(8'h3C, 1'b1);

      // random phases, each under its own limit; every third has no idling
      for (int p = 0; p < PHASES; p++) begin
         if (p == 7) lim = DIST_W'($urandom_range(1, 12));
         else if (p == 9) lim = DIST_W'($urandom_range(0, 511));
         else lim = DIST_W'(phase_limits[p]);
         set_limit(lim);
         calm = (p % 3 == 2);
         repeat (PHASE_ITEMS) push_random_symbol();
      end

      // drain and verdict
      req_bus.valid = 1'b0;
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
